// ===== rtl/best_fit_page_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// best_fit_page_allocator_defines
// assertion macros for the page allocator
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_PAGE_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_PAGE_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define BFPA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define BFPA_ASSERT_R(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define BFPA_ASSERT(label, clk, rst, prop)
`define BFPA_ASSERT_R(label, clk, prop)
`endif
`endif

// ===== rtl/bfpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfpa_pkg
// types and codes shared by the page allocator modules
// ----------------------------------------------------------------------------
`default_nettype none
package bfpa_pkg;
   localparam int unsigned IDX_W = 14;
   localparam int unsigned CNT_W = 15;

   // page space size, tied to the page index width
   localparam int unsigned PAGE_COUNT = 16384;
   localparam logic [CNT_W-1:0] PAGE_LIMIT = CNT_W'(PAGE_COUNT);

   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE  = 2'd1;
   localparam logic [1:0] CMD_ADD   = 2'd2;
   localparam logic [1:0] CMD_SPARE = 2'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NOFIT  = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_ZERO   = 2'd3;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [IDX_W-1:0] page_index;
      logic [CNT_W-1:0] page_count;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [IDX_W-1:0] base_page;
      logic [CNT_W-1:0] pages_free;
   } rsp_type;

   typedef struct packed {
      logic [IDX_W-1:0] start;
      logic [CNT_W-1:0] len;
   } run_type;

   // operations that the controller drives into the chain of cells
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_SHIFT_UP,
      OP_SHIFT_DOWN
   } op_type;

   typedef struct packed {
      op_type           op;
      logic             wr;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_EDIT
   } state_type;
endpackage
`default_nettype wire

// ===== rtl/bfpa_cell.sv =====
// ----------------------------------------------------------------------------
// bfpa_cell
// one slot of the run table; shifts with its neighbours or takes a new run
// ----------------------------------------------------------------------------
`default_nettype none
module bfpa_cell (
   input  wire logic                   clock,
   input  wire bfpa_pkg::cell_ctl_type ctl,
   input  wire bfpa_pkg::run_type      wr_run,
   input  wire bfpa_pkg::run_type      from_prev,
   input  wire bfpa_pkg::run_type      from_next,
   output bfpa_pkg::run_type           run
);
   bfpa_pkg::run_type run_ff, run_in;

   always_comb begin
      run_in = run_ff;
      if (ctl.wr) begin
         run_in = wr_run;
      end else begin
         case (ctl.op)
            bfpa_pkg::OP_SHIFT_DOWN: run_in = from_next;
            bfpa_pkg::OP_SHIFT_UP:   run_in = from_prev;
            default:                 run_in = run_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
   end

   assign run = run_ff;
endmodule
`default_nettype wire

// ===== rtl/best_fit_page_allocator.sv =====
// ----------------------------------------------------------------------------
// best_fit_page_allocator
// best-fit page run allocator with merge on free, run table in a cell chain
// ----------------------------------------------------------------------------
//  channel  direction  word
//  req_     in         cmd, page_index, page_count
//  rsp_     out        status, base_page, pages_free
//
//  a word is accepted in S_IDLE; S_SCAN rotates the table once through
//  cell 0, and S_EDIT applies the edit in place and registers the result.
//  reset clears the run count and the free total; table cells keep no reset.
//  a new word is taken while the last result still waits; its edit cycle
//  stalls until the output register is free.
`default_nettype none
`include "best_fit_page_allocator_defines.svh"
module best_fit_page_allocator #(
   parameter int unsigned MAX_RUNS   = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire bfpa_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output bfpa_pkg::rsp_type       rsp_data
);
   localparam int unsigned CW = $clog2(MAX_RUNS + 1);
   localparam int unsigned SW = $clog2(bfpa_pkg::PAGE_COUNT + 1) + 1;

   bfpa_pkg::run_type      cells [MAX_RUNS];
   bfpa_pkg::cell_ctl_type ctl [MAX_RUNS];
   bfpa_pkg::run_type      head;
   bfpa_pkg::run_type      ed_run;
   logic rot, ed_wr, ed_up, ed_down;
   logic [CW-1:0] ed_idx, ed_pos;

   bfpa_pkg::state_type state_ff, state_in;
   bfpa_pkg::req_type req_ff, req_in;
   logic [CW-1:0] count_ff, count_in;
   logic [bfpa_pkg::CNT_W-1:0] total_ff, total_in;
   logic [CW-1:0] step_ff, step_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] best_ff, best_in;
   logic [bfpa_pkg::IDX_W-1:0] bstart_ff, bstart_in;
   logic [bfpa_pkg::CNT_W-1:0] blen_ff, blen_in;
   logic found_ff, found_in;
   logic mp_ff, mp_in, mn_ff, mn_in;
   logic [bfpa_pkg::IDX_W-1:0] pstart_ff, pstart_in;
   logic [bfpa_pkg::CNT_W-1:0] plen_ff, plen_in;
   logic [bfpa_pkg::CNT_W-1:0] nlen_ff, nlen_in;
   bfpa_pkg::rsp_type rsp_ff, rsp_in;
   logic rv_ff, rv_in;

   logic [SW-1:0] end_prev, in_end;
   logic in_range;
   logic merge_prev, merge_next;

   genvar g;
   generate
      for (g = 0; g < MAX_RUNS; g++) begin : g_cell
         bfpa_cell u_cell (
            .clock    (clock),
            .ctl      (ctl[g]),
            .wr_run   (ed_run),
            .from_prev(cells[(g + MAX_RUNS - 1) % MAX_RUNS]),
            .from_next(cells[(g + 1) % MAX_RUNS]),
            .run      (cells[g])
         );
      end
   endgenerate

   // per-cell control: rotate, close a gap, open a gap, write one slot
   always_comb begin
      for (int unsigned i = 0; i < MAX_RUNS; i++) begin
         ctl[i].op = bfpa_pkg::OP_HOLD;
         ctl[i].wr = 1'b0;
         if (rot || (ed_down && CW'(i) >= ed_pos)) begin
            ctl[i].op = bfpa_pkg::OP_SHIFT_DOWN;
         end else if (ed_up && CW'(i) > ed_pos) begin
            ctl[i].op = bfpa_pkg::OP_SHIFT_UP;
         end
         if (ed_wr && CW'(i) == ed_idx) begin
            ctl[i].wr = 1'b1;
         end
      end
   end

   assign head = cells[0];
   assign in_end = SW'(req_ff.page_index) + SW'(req_ff.page_count);
   assign end_prev = SW'(head.start) + SW'(head.len);
   assign in_range = (in_end <= SW'(bfpa_pkg::PAGE_COUNT)) &&
      (SW'(total_ff) + SW'(req_ff.page_count) <= SW'(bfpa_pkg::PAGE_COUNT));
   assign merge_prev = (req_ff.cmd == bfpa_pkg::CMD_FREE) && mp_ff;
   assign merge_next = (req_ff.cmd == bfpa_pkg::CMD_FREE) && mn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfpa_pkg::S_IDLE;
         count_ff <= '0;
         total_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         total_ff <= total_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in; step_ff <= step_in; pos_ff <= pos_in;
      best_ff <= best_in; bstart_ff <= bstart_in; blen_ff <= blen_in;
      found_ff <= found_in; mp_ff <= mp_in; mn_ff <= mn_in;
      pstart_ff <= pstart_in; plen_ff <= plen_in; nlen_ff <= nlen_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in = state_ff; req_in = req_ff; count_in = count_ff; total_in = total_ff;
      step_in = step_ff; pos_in = pos_ff; best_in = best_ff; bstart_in = bstart_ff;
      blen_in = blen_ff; found_in = found_ff; mp_in = mp_ff; mn_in = mn_ff;
      pstart_in = pstart_ff; plen_in = plen_ff; nlen_in = nlen_ff;
      rsp_in = rsp_ff; rv_in = rv_ff;
      rot = 1'b0; ed_wr = 1'b0; ed_up = 1'b0; ed_down = 1'b0;
      ed_idx = '0; ed_pos = '0; ed_run = head;
      req_ready = 1'b0;
      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end
      case (state_ff)
         bfpa_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in = req_data; step_in = '0; pos_in = '0; found_in = 1'b0;
               mp_in = 1'b0; mn_in = 1'b0;
               state_in = bfpa_pkg::S_SCAN;
            end
         end
         bfpa_pkg::S_SCAN: begin
            // one full rotation: cell 0 holds entry step_ff
            rot = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == CW'(MAX_RUNS - 1)) begin
               state_in = bfpa_pkg::S_EDIT;
            end
            if (step_ff < count_ff) begin
               if (req_ff.cmd == bfpa_pkg::CMD_ALLOC) begin
                  if (head.len >= req_ff.page_count &&
                      (!found_ff || head.len < blen_ff)) begin
                     found_in = 1'b1; best_in = step_ff;
                     bstart_in = head.start; blen_in = head.len;
                  end
               end else if (head.start <= req_ff.page_index) begin
                  pos_in = step_ff + 1'b1;
                  mp_in = (end_prev == SW'(req_ff.page_index));
                  pstart_in = head.start; plen_in = head.len;
               end else if (step_ff == pos_ff) begin
                  mn_in = (in_end == SW'(head.start));
                  nlen_in = head.len;
               end
            end
         end
         bfpa_pkg::S_EDIT: begin
            // table is back in order; edit in place once the output is free
            if (!rv_ff || rsp_ready) begin
               state_in = bfpa_pkg::S_IDLE;
               rv_in = 1'b1;
               rsp_in = '0;
               rsp_in.status = bfpa_pkg::ST_OK;
               if (req_ff.cmd == bfpa_pkg::CMD_SPARE) begin
                  rsp_in.status = bfpa_pkg::ST_OK;
               end else if (req_ff.page_count == '0) begin
                  rsp_in.status = bfpa_pkg::ST_ZERO;
               end else if (req_ff.cmd == bfpa_pkg::CMD_ALLOC) begin
                  if (req_ff.page_count > total_ff || !found_ff) begin
                     rsp_in.status = bfpa_pkg::ST_NOFIT;
                  end else begin
                     rsp_in.base_page = bstart_ff;
                     total_in = total_ff - req_ff.page_count;
                     if (blen_ff > req_ff.page_count) begin
                        ed_wr = 1'b1; ed_idx = best_ff;
                        ed_run.start = bstart_ff + req_ff.page_count[bfpa_pkg::IDX_W-1:0];
                        ed_run.len = blen_ff - req_ff.page_count;
                     end else begin
                        ed_down = 1'b1; ed_pos = best_ff;
                        count_in = count_ff - 1'b1;
                     end
                  end
               end else if (!in_range) begin
                  rsp_in.status = bfpa_pkg::ST_NOFIT;
               end else if (merge_prev && merge_next) begin
                  ed_wr = 1'b1; ed_idx = pos_ff - 1'b1;
                  ed_run.start = pstart_ff;
                  ed_run.len = plen_ff + req_ff.page_count + nlen_ff;
                  ed_down = 1'b1; ed_pos = pos_ff;
                  count_in = count_ff - 1'b1;
                  total_in = total_ff + req_ff.page_count;
               end else if (merge_prev) begin
                  ed_wr = 1'b1; ed_idx = pos_ff - 1'b1;
                  ed_run.start = pstart_ff;
                  ed_run.len = plen_ff + req_ff.page_count;
                  total_in = total_ff + req_ff.page_count;
               end else if (merge_next) begin
                  ed_wr = 1'b1; ed_idx = pos_ff;
                  ed_run.start = req_ff.page_index;
                  ed_run.len = nlen_ff + req_ff.page_count;
                  total_in = total_ff + req_ff.page_count;
               end else if (count_ff >= CW'(MAX_RUNS)) begin
                  rsp_in.status = bfpa_pkg::ST_FULL;
               end else begin
                  ed_up = 1'b1; ed_pos = pos_ff;
                  ed_wr = 1'b1; ed_idx = pos_ff;
                  ed_run.start = req_ff.page_index;
                  ed_run.len = req_ff.page_count;
                  count_in = count_ff + 1'b1;
                  total_in = total_ff + req_ff.page_count;
               end
               rsp_in.pages_free = total_in;
            end
         end
         default: state_in = bfpa_pkg::S_IDLE;
      endcase
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   `BFPA_ASSERT(a_cnt_max, clock, reset, count_ff <= CW'(MAX_RUNS))
   `BFPA_ASSERT(a_tot_max, clock, reset, total_ff <= bfpa_pkg::PAGE_LIMIT)
   `BFPA_ASSERT(a_rdy_idle, clock, reset, req_ready |-> state_ff == bfpa_pkg::S_IDLE)
   `BFPA_ASSERT_R(a_rst, clock, reset |=> !rsp_valid)
endmodule
`default_nettype wire

// ===== test/best_fit_page_allocator_test.sv =====
// ----------------------------------------------------------------------------
// best_fit_page_allocator_test
// drives allocate, free, add-region and spare words with random gaps and stalls,
// predicts every response from a local copy of the run table and checks it
// ----------------------------------------------------------------------------
`default_nettype none
module best_fit_page_allocator_test;
   localparam int unsigned RUNS  = 64;

   class alloc_scoreboard;
      int unsigned starts[RUNS];
      int unsigned lens[RUNS];
      int unsigned nruns;
      int unsigned total;
      bfpa_pkg::rsp_type pending[$];
      int          mismatches;
      int          checked;

      function new();
         nruns = 0;
         total = 0;
         mismatches = 0;
         checked = 0;
      endfunction

      function void drop_run(int unsigned pos);
         for (int unsigned i = pos; i + 1 < nruns; i++) begin
            starts[i] = starts[i+1];
            lens[i] = lens[i+1];
         end
         nruns--;
      endfunction

      function logic [1:0] take_run(int unsigned n, output int unsigned base);
         int unsigned best;
         int unsigned best_len;
         bit found;
         best = 0;
         best_len = 0;
         found = 0;
         base = 0;
         if (n > total) return bfpa_pkg::ST_NOFIT;
         for (int unsigned i = 0; i < nruns; i++)
            if (lens[i] >= n && (!found || lens[i] < best_len)) begin
               found = 1;
               best = i;
               best_len = lens[i];
            end
         if (!found) return bfpa_pkg::ST_NOFIT;
         base = starts[best];
         if (best_len > n) begin
            starts[best] = (starts[best] + n) & 16'h3fff;
            lens[best] = best_len - n;
         end else begin
            drop_run(best);
         end
         total -= n;
         return bfpa_pkg::ST_OK;
      endfunction

      function logic [1:0] place_run(int unsigned base, int unsigned n, bit merge);
         int unsigned pos;
         bit mp;
         bit mn;
         pos = 0;
         mp = 0;
         mn = 0;
         if (base + n > bfpa_pkg::PAGE_COUNT || total + n > bfpa_pkg::PAGE_COUNT)
            return bfpa_pkg::ST_NOFIT;
         while (pos < nruns && starts[pos] <= base) pos++;
         if (merge) begin
            mp = pos > 0 && starts[pos-1] + lens[pos-1] == base;
            mn = pos < nruns && base + n == starts[pos];
         end
         if (mp && mn) begin
            lens[pos-1] = lens[pos-1] + n + lens[pos];
            drop_run(pos);
         end else if (mp) begin
            lens[pos-1] += n;
         end else if (mn) begin
            starts[pos] = base;
            lens[pos] += n;
         end else begin
            if (nruns >= RUNS) return bfpa_pkg::ST_FULL;
            for (int unsigned i = nruns; i > pos; i--) begin
               starts[i] = starts[i-1];
               lens[i] = lens[i-1];
            end
            starts[pos] = base;
            lens[pos] = n;
            nruns++;
         end
         total += n;
         return bfpa_pkg::ST_OK;
      endfunction

      function void note_word(bfpa_pkg::req_type w);
         bfpa_pkg::rsp_type r;
         int unsigned got;
         got = 0;
         r = '0;
         if (w.cmd == bfpa_pkg::CMD_SPARE) r.status = bfpa_pkg::ST_OK;
         else if (w.page_count == 0) r.status = bfpa_pkg::ST_ZERO;
         else if (w.cmd == bfpa_pkg::CMD_ALLOC) r.status = take_run(w.page_count, got);
         else r.status = place_run(w.page_index, w.page_count,
                                   w.cmd == bfpa_pkg::CMD_FREE);
         r.base_page = (w.cmd == bfpa_pkg::CMD_ALLOC && r.status == bfpa_pkg::ST_OK) ?
                       got[13:0] : '0;
         r.pages_free = total[14:0];
         pending.push_back(r);
      endfunction

      function void check_word(bfpa_pkg::rsp_type got);
         bfpa_pkg::rsp_type exp;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
            return;
         end
         exp = pending.pop_front();
         if (got.status !== exp.status || got.base_page !== exp.base_page ||
             got.pages_free !== exp.pages_free) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: status %0d/%0d base %0d/%0d free %0d/%0d",
                        exp.status, got.status, exp.base_page, got.base_page,
                        exp.pages_free, got.pages_free);
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   bfpa_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   bfpa_pkg::rsp_type rsp_data;
   bit      sending = 1;
   int      sent = 0;

   alloc_scoreboard board = new();

   best_fit_page_allocator DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   function automatic int pick_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
   endfunction

   task automatic send_word(logic [1:0] cmd, int unsigned idx, int unsigned cnt);
      int gap;
      gap = (sent % 150 < 40) ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= '{cmd: cmd, page_index: idx[13:0], page_count: cnt[14:0]};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_word(req_data);
      sent++;
   endtask

   // response side: random stalls, checked on accepting edges
   initial begin
      int hold;
      hold = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) board.check_word(rsp_data);
         if (!sending) begin
            rsp_ready <= 1;
         end else if (hold > 0) begin
            hold--;
            rsp_ready <= 0;
         end else if ($urandom_range(0, 1) == 0) begin
            rsp_ready <= 1;
         end else begin
            hold = pick_gap();
            rsp_ready <= 0;
         end
      end
   end

   initial begin
      int unsigned k;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: empty table, zero counts, spare command, extremes
      send_word(bfpa_pkg::CMD_ALLOC, 0, 1);
      send_word(bfpa_pkg::CMD_ALLOC, 0, 0);
      send_word(bfpa_pkg::CMD_FREE, 0, 0);
      send_word(bfpa_pkg::CMD_ADD, 16383, 0);
      send_word(bfpa_pkg::CMD_SPARE, 16383, 32767);
      send_word(bfpa_pkg::CMD_ADD, 16383, 2);
      send_word(bfpa_pkg::CMD_ADD, 0, 16384);
      send_word(bfpa_pkg::CMD_ALLOC, 0, 16384);
      send_word(bfpa_pkg::CMD_FREE, 0, 100);
      send_word(bfpa_pkg::CMD_FREE, 200, 100);
      send_word(bfpa_pkg::CMD_FREE, 100, 100);
      send_word(bfpa_pkg::CMD_ALLOC, 0, 300);
      send_word(bfpa_pkg::CMD_ADD, 1000, 10);
      send_word(bfpa_pkg::CMD_ADD, 1000, 5);
      send_word(bfpa_pkg::CMD_ADD, 500, 5);
      send_word(bfpa_pkg::CMD_FREE, 1010, 3);
      send_word(bfpa_pkg::CMD_FREE, 995, 5);
      send_word(bfpa_pkg::CMD_ALLOC, 0, 5);
      send_word(bfpa_pkg::CMD_ALLOC, 0, 20000);
      send_word(bfpa_pkg::CMD_ADD, 16383, 1);
      send_word(bfpa_pkg::CMD_ALLOC, 0, 18);
      send_word(bfpa_pkg::CMD_ALLOC, 0, 1);
      // fill the table to full with separated runs, then hit the limit
      for (k = 0; k < 66; k++) send_word(bfpa_pkg::CMD_ADD, 2000 + k * 4, 2);
      send_word(bfpa_pkg::CMD_FREE, 2000 + 64 * 4 + 1, 1);
      send_word(bfpa_pkg::CMD_FREE, 2002, 2);
      send_word(bfpa_pkg::CMD_FREE, 8000, 1);
      for (k = 0; k < 70; k++) send_word(bfpa_pkg::CMD_ALLOC, 0, 2);
      // random: well-formed churn plus noise
      for (k = 0; k < 440; k++) begin
         int unsigned r;
         int unsigned b;
         int unsigned c;
         r = $urandom_range(0, 99);
         c = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767) : $urandom_range(1, 64);
         b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383)
                                         : $urandom_range(0, 255) * 64;
         if (r < 40) send_word(bfpa_pkg::CMD_ALLOC, $urandom_range(0, 16383), c);
         else if (r < 75) send_word(bfpa_pkg::CMD_FREE, b, c);
         else if (r < 95) send_word(bfpa_pkg::CMD_ADD, b, c);
         else send_word(bfpa_pkg::CMD_SPARE, $urandom_range(0, 16383),
                        $urandom_range(0, 32767));
      end
      req_valid <= 0;
      sending = 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("words sent %0d, responses checked %0d, runs left %0d",
               sent, board.checked, board.nruns);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #40000000;
      $display("TB_ERROR");
      $finish;
   end
endmodule
`default_nettype wire
